/* design/hrpc_pkg.sv */
// Shared types, constants and a helper function for the HLS to RGB pixel converter.
package hrpc_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int HUE_W  = 14;   // hue position in 1/32 degree, 0..11519
    localparam int MIX_W  = 17;   // m1 and m2-m1 numerators over 255*255
    localparam int WGT_W  = 11;   // ramp weight, 0..1920
    localparam int SUM_W  = 27;   // channel numerator plus rounding offset
    localparam int QUO_W  = 20;   // numerator after the power-of-two part of the divisor
    localparam int RCP_W  = 21;
    localparam int PRD_W  = QUO_W + RCP_W;

    // Hue geometry in 1/32 degree units.
    localparam logic [HUE_W-1:0] HUE_STEP = 14'd45;
    localparam logic [HUE_W-1:0] DEG60    = 14'd1920;
    localparam logic [HUE_W-1:0] DEG120   = 14'd3840;
    localparam logic [HUE_W-1:0] DEG180   = 14'd5760;
    localparam logic [HUE_W-1:0] DEG240   = 14'd7680;
    localparam logic [HUE_W-1:0] DEG360   = 14'd11520;

    // Rounding: byte = floor((num + 244800) / 489600), 489600 = 128 * 3825.
    localparam logic [SUM_W-1:0] ROUND_OFS = 27'd244800;
    localparam int               DIV_SHIFT = 7;
    // ceil(2^32 / 3825); exact for every quotient input below 2^20.
    localparam logic [RCP_W-1:0] RECIP     = 21'd1122868;
    localparam int               RCP_SHIFT = 32;

    // Blend factors shared by the three channels.
    typedef struct packed {
        logic [MIX_W-1:0] m1;     // floor level
        logic [MIX_W-1:0] span;   // m2 - m1, never negative
    } mix_t;

    // Position on the piecewise channel curve, scaled so 1920 means m2.
    function automatic logic [WGT_W-1:0] ramp_weight(input logic [HUE_W-1:0] h);
        logic [HUE_W-1:0] fall;
        begin
            fall = DEG240 - h;
            if (h < DEG60)
                ramp_weight = h[WGT_W-1:0];
            else if (h < DEG180)
                ramp_weight = DEG60[WGT_W-1:0];
            else if (h < DEG240)
                ramp_weight = fall[WGT_W-1:0];
            else
                ramp_weight = '0;
        end
    endfunction

endpackage

/* design/hrpc_prep.sv */
// First stage: blend factors m1 and m2-m1 and the ramp weight of each channel.
module hrpc_prep
    import hrpc_pkg::*;
(
    input  logic              clk,
    input  logic              load,
    input  logic [BYTE_W-1:0] hue,
    input  logic [BYTE_W-1:0] lightness,
    input  logic [BYTE_W-1:0] saturation,
    output mix_t              mix,
    output logic [WGT_W-1:0]  wgt_red,
    output logic [WGT_W-1:0]  wgt_green,
    output logic [WGT_W-1:0]  wgt_blue
);

    logic [BYTE_W-1:0]   fold;
    logic [2*BYTE_W-1:0] prod;
    logic [MIX_W-1:0]    base;
    logic [HUE_W-1:0]    h_green;
    logic [HUE_W-1:0]    h_red_raw;
    logic [HUE_W-1:0]    h_red;
    logic [HUE_W-1:0]    h_blue;
    mix_t                mix_next;
    mix_t                mix_reg;
    logic [WGT_W-1:0]    wr_reg, wg_reg, wb_reg;

    // m2 = 255*l + s*t with t = l or 255-l; m1 = 255*l - s*t, span = 2*s*t.
    always_comb
    begin
        fold          = lightness[BYTE_W-1] ? (8'd255 - lightness) : lightness;
        prod          = saturation * fold;
        base          = MIX_W'(lightness) * 17'd255;
        mix_next.m1   = base - MIX_W'(prod);
        mix_next.span = {prod, 1'b0};
    end

    // Hue positions of the three channels, wrapped into one turn.
    always_comb
    begin
        h_green   = HUE_W'(hue) * HUE_STEP;
        h_red_raw = h_green + DEG120;
        h_red     = (h_red_raw >= DEG360) ? (h_red_raw - DEG360) : h_red_raw;
        h_blue    = (h_green >= DEG120) ? (h_green - DEG120) : (h_green + DEG240);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mix_reg <= mix_next;
            wr_reg  <= ramp_weight(h_red);
            wg_reg  <= ramp_weight(h_green);
            wb_reg  <= ramp_weight(h_blue);
        end
    end

    assign mix       = mix_reg;
    assign wgt_red   = wr_reg;
    assign wgt_green = wg_reg;
    assign wgt_blue  = wb_reg;

endmodule

/* design/hrpc_chan.sv */
// Second and third stages of one color channel: blend, then scale and round to a byte.
module hrpc_chan
    import hrpc_pkg::*;
(
    input  logic              clk,
    input  logic              load_blend,
    input  logic              load_round,
    input  mix_t              mix,
    input  logic [WGT_W-1:0]  wgt,
    output logic [BYTE_W-1:0] level
);

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [QUO_W-1:0]  quo;
    logic [PRD_W-1:0]  prd;
    logic [BYTE_W-1:0] level_next;
    logic [BYTE_W-1:0] level_reg;

    // Numerator m1*1920 + span*w, plus half the divisor for rounding.
    always_comb
    begin
        sum_next = (SUM_W'(mix.m1) << 11) - (SUM_W'(mix.m1) << 7)
                 + SUM_W'(mix.span) * SUM_W'(wgt) + ROUND_OFS;
    end

    // Divide by 128*3825: a shift, then a reciprocal multiply.
    always_comb
    begin
        quo        = sum_reg[SUM_W-1:DIV_SHIFT];
        prd        = PRD_W'(quo) * PRD_W'(RECIP);
        level_next = prd[RCP_SHIFT+BYTE_W-1:RCP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (load_blend)
            sum_reg <= sum_next;
        if (load_round)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

/* design/hls_to_rgb_pixel_convert_core.sv */
// Top level of the HLS to RGB pixel converter: stream ports and pipeline control.
//
//  Channel | Direction | Handshake                | Payload
//  s_axis  | in        | s_axis_tvalid/tready     | tdata: hue, lightness, saturation; tlast
//  m_axis  | out       | m_axis_tvalid/tready     | tdata: red, green, blue; tlast
//
// Three register stages: blend factors and ramp weights, channel numerator,
// reciprocal-multiply rounding into the output register.
// One item per cycle when the output is taken.
// Each stage holds its item while the next one is full and stalled; an empty
// stage fills even when the output is stalled, so no item is lost or repeated.
// Reset clears only the valid bits.
module hls_to_rgb_pixel_convert_core
    import hrpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] hue, [15:8] lightness, [23:16] saturation
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_axis_tlast
);

    logic             v1_reg, v2_reg, v3_reg;
    logic             v1_next, v2_next, v3_next;
    logic             last1_reg, last2_reg, last3_reg;
    logic             rdy1, rdy2, rdy3;
    logic             load1, load2, load3;
    mix_t             mix;
    logic [WGT_W-1:0] wgt_red, wgt_green, wgt_blue;
    logic [BYTE_W-1:0] red, green, blue;

    // A stage can take a new item when empty or when its item moves on.
    always_comb
    begin
        rdy3    = !v3_reg || m_axis_tready;
        rdy2    = !v2_reg || rdy3;
        rdy1    = !v1_reg || rdy2;
        load1   = rdy1 && s_axis_tvalid;
        load2   = rdy2 && v1_reg;
        load3   = rdy3 && v2_reg;
        v1_next = rdy1 ? s_axis_tvalid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // The last flag travels beside the data.
    always_ff @(posedge clk)
    begin
        if (load1)
            last1_reg <= s_axis_tlast;
        if (load2)
            last2_reg <= last1_reg;
        if (load3)
            last3_reg <= last2_reg;
    end

    hrpc_prep u_prep (
        .clk        (clk),
        .load       (load1),
        .hue        (s_axis_tdata[7:0]),
        .lightness  (s_axis_tdata[15:8]),
        .saturation (s_axis_tdata[23:16]),
        .mix        (mix),
        .wgt_red    (wgt_red),
        .wgt_green  (wgt_green),
        .wgt_blue   (wgt_blue)
    );

    hrpc_chan u_red (
        .clk        (clk),
        .load_blend (load2),
        .load_round (load3),
        .mix        (mix),
        .wgt        (wgt_red),
        .level      (red)
    );

    hrpc_chan u_green (
        .clk        (clk),
        .load_blend (load2),
        .load_round (load3),
        .mix        (mix),
        .wgt        (wgt_green),
        .level      (green)
    );

    hrpc_chan u_blue (
        .clk        (clk),
        .load_blend (load2),
        .load_round (load3),
        .mix        (mix),
        .wgt        (wgt_blue),
        .level      (blue)
    );

    assign s_axis_tready = rdy1;
    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {blue, green, red};
    assign m_axis_tlast  = last3_reg;

endmodule

/* design/hrpc_checker.sv */
// Port-level checks of the HLS to RGB pixel converter, bound to the top level.
module hrpc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // An edge taken in reset leaves the output empty afterwards.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // With the output drained every cycle the pipeline never pushes back.
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // A stalled item stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    // A stalled item keeps its payload.
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

endmodule

bind hls_to_rgb_pixel_convert_core hrpc_checker u_hrpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* tb/tb_hls_to_rgb_pixel_convert_core.sv */
// Self-checking stream testbench for the HLS to RGB pixel converter core.
module tb_hls_to_rgb_pixel_convert_core;

    // Hue geometry in 1/32 degree units and the rounding divisor.
    localparam int HUE_UNIT   = 45;
    localparam int HUE_60     = 1920;
    localparam int HUE_120    = 3840;
    localparam int HUE_180    = 5760;
    localparam int HUE_240    = 7680;
    localparam int HUE_360    = 11520;
    localparam int LEVEL_DIV  = 489600;    // 255 * 1920
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 540;
    localparam int DRAIN_CYCLES = 12;

    // One converted pixel as it leaves the block.
    typedef struct packed {
        logic       last;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_pixel_t;

    // Holds the expected pixels in order and compares them with the output.
    class pixel_scoreboard;
        rgb_pixel_t expected_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // Channel byte from the blend levels and the channel's hue position.
        function int channel_level(input int m1, input int m2, input int h);
            int    pos;
            int    w;
            longint num;
            begin
                pos = h;
                if (pos < 0)
                    pos = pos + HUE_360;
                if (pos >= HUE_360)
                    pos = pos - HUE_360;
                if (pos < HUE_60)
                    w = pos;
                else if (pos < HUE_180)
                    w = HUE_60;
                else if (pos < HUE_240)
                    w = HUE_240 - pos;
                else
                    w = 0;
                num = longint'(m1) * HUE_60 + longint'(m2 - m1) * w;
                channel_level = int'((2 * num + LEVEL_DIV) / (2 * longint'(LEVEL_DIV)));
            end
        endfunction

        // Exact integer HLS to RGB conversion of one pixel.
        function rgb_pixel_t convert_hls(input logic [7:0] hb, input logic [7:0] lb,
                                         input logic [7:0] sb, input logic last);
            int         l;
            int         s;
            int         m1;
            int         m2;
            int         h;
            rgb_pixel_t px;
            begin
                l = lb;
                s = sb;
                h = int'(hb) * HUE_UNIT;
                if (l <= 127)
                    m2 = l * (255 + s);
                else
                    m2 = 255 * l + 255 * s - l * s;
                m1 = 510 * l - m2;
                px.red   = 8'(channel_level(m1, m2, h + HUE_120));
                px.green = 8'(channel_level(m1, m2, h));
                px.blue  = 8'(channel_level(m1, m2, h - HUE_120));
                px.last  = last;
                convert_hls = px;
            end
        endfunction

        task report_mismatch(input string msg);
            begin
                $display("ERROR: %s", msg);
                errors = errors + 1;
            end
        endtask

        task note_pixel(input logic [23:0] data, input logic last);
            begin
                expected_q.push_back(convert_hls(data[7:0], data[15:8], data[23:16], last));
            end
        endtask

        task check_pixel(input logic [23:0] data, input logic last);
            rgb_pixel_t exp_px;
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("output item %h with none expected", data));
                end
                else
                begin
                    exp_px = expected_q.pop_front();
                    if (data[7:0] !== exp_px.red)
                        report_mismatch($sformatf("red %0d, expected %0d",
                                                  data[7:0], exp_px.red));
                    if (data[15:8] !== exp_px.green)
                        report_mismatch($sformatf("green %0d, expected %0d",
                                                  data[15:8], exp_px.green));
                    if (data[23:16] !== exp_px.blue)
                        report_mismatch($sformatf("blue %0d, expected %0d",
                                                  data[23:16], exp_px.blue));
                    if (last !== exp_px.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  last, exp_px.last));
                end
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    int src_idle_pct  = 34;
    int sink_idle_pct = 70;
    int cycle_count   = 0;

    pixel_scoreboard sb = new();

    hls_to_rgb_pixel_convert_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL hls_to_rgb_pixel_convert_core");
            $finish;
        end
    end

    // The receiver stalls at random.
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Note every accepted input item and check every accepted output item.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_pixel(s_axis_tdata, s_axis_tlast);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tlast);
    end

    // Offer one pixel, with a random gap first, and return at its accepting edge.
    task send_pixel(input logic [7:0] hb, input logic [7:0] lb, input logic [7:0] sbyte,
                    input logic last);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {sbyte, lb, hb};
            s_axis_tlast  <= last;
            @(negedge clk);
            while (!s_axis_tready)
                @(negedge clk);
            @(posedge clk);
        end
    endtask

    // Field value biased toward the ends and the middle of the range.
    function logic [7:0] pick_byte();
        logic [7:0] v;
        begin
            case ($urandom_range(9))
                0: v = 8'd0;
                1: v = 8'd255;
                2: v = 8'd127 + 8'($urandom_range(1));
                default: v = 8'($urandom);
            endcase
            pick_byte = v;
        end
    endfunction

    // Directed pixels: range extremes, sector edges, the lightness split,
    // and two exact rounding ties on the green ramp.
    task send_directed();
        begin
            send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
            send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
            send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
            send_pixel(8'd255, 8'd0,   8'd255, 1'b0);
            send_pixel(8'd0,   8'd127, 8'd255, 1'b1);
            send_pixel(8'd0,   8'd128, 8'd255, 1'b0);
            send_pixel(8'd42,  8'd127, 8'd255, 1'b0);
            send_pixel(8'd43,  8'd128, 8'd200, 1'b1);
            send_pixel(8'd85,  8'd128, 8'd200, 1'b0);
            send_pixel(8'd86,  8'd1,   8'd254, 1'b0);
            send_pixel(8'd128, 8'd64,  8'd255, 1'b0);
            send_pixel(8'd170, 8'd200, 8'd128, 1'b1);
            send_pixel(8'd171, 8'd127, 8'd255, 1'b0);
            send_pixel(8'd213, 8'd128, 8'd255, 1'b0);
            send_pixel(8'd214, 8'd60,  8'd90,  1'b1);
            send_pixel(8'd255, 8'd127, 8'd128, 1'b0);
            send_pixel(8'd128, 8'd128, 8'd127, 1'b0);
            send_pixel(8'd0,   8'd128, 8'd0,   1'b1);
            send_pixel(8'd32,  8'd85,  8'd3,   1'b0);
            send_pixel(8'd32,  8'd85,  8'd195, 1'b1);
        end
    endtask

    task send_random(input int count);
        int n;
        begin
            for (n = 0; n < count; n++)
                send_pixel(pick_byte(), pick_byte(), pick_byte(),
                           ($urandom_range(7) == 0));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles less than the receiver.
        src_idle_pct  = 34;
        sink_idle_pct = 70;
        send_directed();
        send_random(RANDOM_PER_PHASE);

        // Sender idles more than the receiver.
        src_idle_pct  = 70;
        sink_idle_pct = 34;
        send_random(RANDOM_PER_PHASE);

        // Back-to-back items at full rate.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_random(RANDOM_PER_PHASE);
        s_axis_tvalid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report_mismatch("expected items left over at the end");

        if (sb.errors == 0)
            $display("PASS hls_to_rgb_pixel_convert_core");
        else
            $display("FAIL hls_to_rgb_pixel_convert_core");
        $finish;
    end

endmodule
